// File: rtl/ack_congestion_rtt_tracker_assert.svh
// Assertion macros for the ack congestion and RTT tracker checker
`ifndef ACK_CONGESTION_RTT_TRACKER_ASSERT_SVH
`define ACK_CONGESTION_RTT_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ACRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ACRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/acrt_pkg.sv
// Shared constants and types of the ack congestion and RTT tracker
package acrt_pkg;

  localparam int GROWTH_STEP     = 1024;
  localparam int WINDOW_CAPACITY = 4096;

  localparam int CNT_W    = 13;
  localparam int POS_W    = 32;
  localparam int WIN_W    = 24;
  localparam int AVG_W    = 24;
  localparam int SAMPLE_W = 20;
  localparam int LOW_W    = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FRAC_W   = 4;

  localparam int GROWTH_SQ = GROWTH_STEP * GROWTH_STEP;
  localparam int QUO_W     = $clog2(GROWTH_SQ + 1);
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int REM_W     = WIN_W + 1;

  localparam int ALPHA_KEEP  = 230;
  localparam int ALPHA_NEW   = 26;
  localparam int EWMA_SHIFT  = 8;
  localparam int ROUND_BIAS  = 1 << (EWMA_SHIFT - 1);
  localparam int ACC_W       = 33;

  localparam logic [CNT_W-1:0]    CAPACITY        = CNT_W'(WINDOW_CAPACITY);
  localparam logic [WIN_W-1:0]    GROWTH_INC      = WIN_W'(GROWTH_STEP);
  localparam logic [QUO_W-1:0]    GROWTH_SQ_Q     = QUO_W'(GROWTH_SQ);
  localparam logic [WIN_W-1:0]    WIN_MAX         = {WIN_W{1'b1}};
  localparam logic [AVG_W-1:0]    AVG_MAX         = {AVG_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = {SAMPLE_W{1'b1}};
  localparam logic [WIN_W-1:0]    THRESHOLD_RESET = WIN_W'(65536);

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STALE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SEND     = 2'd3;

  typedef struct packed {
    logic             start;
    logic [WIN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/ack_congestion_rtt_tracker.sv
// Top level of the ack congestion and RTT tracker: sequencer, state and output register
//
// channel  direction  handshake             payload
// in       sink       in_valid/in_ready     operation ack_low now_time head_resent head_send_time
// out      source     out_valid/out_ready   status acked_count window_start outstanding
//                                           congestion_window rtt_estimate rtt_spread
//                                           backoff_cleared
// cfg      sink       cfg_valid/cfg_ready   cfg_data (slow start threshold)
//
// A send, stale or out-of-window ack goes from S_EVAL straight to S_OUT, which loads the result.
// An accepted ack in slow start passes S_EVAL, then S_RTT, S_DEV and S_WB when RTT is sampled,
// then S_ADV and S_OUT; congestion avoidance puts S_DIV, waiting for the divider, after S_EVAL.
// in_ready is high only while the sequencer is idle; a result waiting at the output holds
// the sequencer before it loads the next one. cfg_ready is always high.
// Reset (rst, synchronous) clears the state, threshold to 65536, window to 1024.
module ack_congestion_rtt_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [acrt_pkg::LOW_W-1:0]    ack_low,
  input  logic [acrt_pkg::TIME_W-1:0]   now_time,
  input  logic                          head_resent,
  input  logic [acrt_pkg::TIME_W-1:0]   head_send_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [acrt_pkg::STATUS_W-1:0] status,
  output logic [acrt_pkg::CNT_W-1:0]    acked_count,
  output logic [acrt_pkg::POS_W-1:0]    window_start,
  output logic [acrt_pkg::CNT_W-1:0]    outstanding,
  output logic [acrt_pkg::WIN_W-1:0]    congestion_window,
  output logic [acrt_pkg::AVG_W-1:0]    rtt_estimate,
  output logic [acrt_pkg::AVG_W-1:0]    rtt_spread,
  output logic                          backoff_cleared,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acrt_pkg::WIN_W-1:0]    cfg_data
);
  import acrt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EVAL = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_RTT  = 8'b0000_1000,
    S_DEV  = 8'b0001_0000,
    S_WB   = 8'b0010_0000,
    S_ADV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  localparam int DIST_W = LOW_W + 2;
  localparam logic signed [DIST_W-1:0] HALF_SPAN = DIST_W'(1) <<< (LOW_W - 1);
  localparam logic signed [DIST_W-1:0] FULL_SPAN = DIST_W'(1) <<< LOW_W;

  state_t state;
  state_t state_next;

  logic                op_r;
  logic [LOW_W-1:0]    low_r;
  logic [TIME_W-1:0]   now_r;
  logic                resent_r;
  logic [TIME_W-1:0]   sent_r;

  logic [WIN_W-1:0]    threshold;
  logic [POS_W-1:0]    start_position;
  logic [CNT_W-1:0]    outstanding_count;
  logic [WIN_W-1:0]    cwnd_value;
  logic [AVG_W-1:0]    rtt_average;
  logic [AVG_W-1:0]    rtt_deviation_average;

  logic [STATUS_W-1:0] status_r;
  logic [CNT_W-1:0]    rel_r;
  logic                cleared_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] dev_r;

  logic signed [DIST_W-1:0] delta;
  logic signed [DIST_W-1:0] rel_s;
  logic                     stale;
  logic                     beyond;
  logic                     slow_start;
  logic [TIME_W-1:0]        elapsed;
  logic [SAMPLE_W-1:0]      sample;
  logic [SAMPLE_W-1:0]      whole;
  logic [WIN_W:0]           slow_sum;
  logic [WIN_W:0]           lin_sum;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [AVG_W-1:0]    ewma_last;
  logic [SAMPLE_W-1:0] ewma_sample;
  logic [AVG_W-1:0]    ewma_result;
  logic                out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    delta = $signed({2'b00, low_r}) - $signed({2'b00, start_position[LOW_W-1:0]});
    if (delta < -HALF_SPAN) begin
      rel_s = delta + FULL_SPAN;
    end else if (delta > HALF_SPAN) begin
      rel_s = delta - FULL_SPAN;
    end else begin
      rel_s = delta;
    end
  end

  assign stale      = (rel_s == '0) || rel_s[DIST_W-1];
  assign beyond     = rel_s[DIST_W-2:0] > (DIST_W-1)'(outstanding_count);
  assign slow_start = cwnd_value < threshold;
  assign elapsed    = now_r - sent_r;
  assign sample     = (elapsed[TIME_W-1:SAMPLE_W] != '0) ? SAMPLE_MAX : elapsed[SAMPLE_W-1:0];
  assign whole      = rtt_average[AVG_W-1:FRAC_W];
  assign slow_sum   = {1'b0, cwnd_value} + {1'b0, GROWTH_INC};
  assign lin_sum    = {1'b0, cwnd_value} + (WIN_W+1)'(div_rsp.quotient);

  assign div_req.start   = (state == S_EVAL) && (op_r == OP_ACK) && !stale && !beyond
                           && !slow_start;
  assign div_req.divisor = cwnd_value;

  assign ewma_last   = (state == S_RTT) ? rtt_average : rtt_deviation_average;
  assign ewma_sample = (state == S_RTT) ? sample_r : dev_r;

  acrt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  acrt_ewma u_ewma (
    .clk    (clk),
    .last   (ewma_last),
    .sample (ewma_sample),
    .result (ewma_result)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (op_r == OP_SEND || stale || beyond) begin
          state_next = S_OUT;
        end else if (!slow_start) begin
          state_next = S_DIV;
        end else begin
          state_next = resent_r ? S_ADV : S_RTT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) state_next = resent_r ? S_ADV : S_RTT;
      end
      S_RTT: state_next = S_DEV;
      S_DEV: state_next = S_WB;
      S_WB:  state_next = S_ADV;
      S_ADV: state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      out_valid             <= 1'b0;
      threshold             <= THRESHOLD_RESET;
      start_position        <= '0;
      outstanding_count     <= '0;
      cwnd_value            <= GROWTH_INC;
      rtt_average           <= '0;
      rtt_deviation_average <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) threshold <= cfg_data;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_EVAL: begin
          if (op_r == OP_SEND) begin
            if (outstanding_count < CAPACITY) begin
              outstanding_count <= outstanding_count + CNT_W'(1);
            end
          end else if (!stale && !beyond && slow_start) begin
            cwnd_value <= slow_sum[WIN_W] ? WIN_MAX : slow_sum[WIN_W-1:0];
          end
        end
        S_DIV: begin
          if (div_rsp.done) cwnd_value <= lin_sum[WIN_W] ? WIN_MAX : lin_sum[WIN_W-1:0];
        end
        S_DEV: rtt_average <= ewma_result;
        S_WB:  rtt_deviation_average <= ewma_result;
        S_ADV: begin
          start_position    <= start_position + POS_W'(rel_r);
          outstanding_count <= outstanding_count - rel_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r     <= operation;
      low_r    <= ack_low;
      now_r    <= now_time;
      resent_r <= head_resent;
      sent_r   <= head_send_time;
    end
    if (state == S_EVAL) begin
      sample_r <= sample;
      if (op_r == OP_SEND) begin
        status_r  <= ST_SEND;
        rel_r     <= '0;
        cleared_r <= 1'b0;
      end else if (stale) begin
        status_r  <= ST_STALE;
        rel_r     <= '0;
        cleared_r <= 1'b0;
      end else if (beyond) begin
        status_r  <= ST_BEYOND;
        rel_r     <= '0;
        cleared_r <= 1'b0;
      end else begin
        status_r  <= ST_ACCEPTED;
        rel_r     <= rel_s[CNT_W-1:0];
        cleared_r <= !resent_r;
      end
    end
    if (state == S_RTT) begin
      dev_r <= (sample_r >= whole) ? sample_r - whole : whole - sample_r;
    end
    if (state == S_OUT && out_free) begin
      status            <= status_r;
      acked_count       <= rel_r;
      window_start      <= start_position;
      outstanding       <= outstanding_count;
      congestion_window <= cwnd_value;
      rtt_estimate      <= rtt_average;
      rtt_spread        <= rtt_deviation_average;
      backoff_cleared   <= cleared_r;
    end
  end

endmodule

// File: rtl/acrt_div.sv
// Iterative restoring divider: growth step squared over the window, one bit a cycle
module acrt_div (
  input  logic              clk,
  input  logic              rst,
  input  acrt_pkg::div_req_t req,
  output acrt_pkg::div_rsp_t rsp
);
  import acrt_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W-1:0]     rem;
  logic [QUO_W-1:0]     quo;
  logic [WIN_W-1:0]     dvs;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  assign trial = {rem[REM_W-2:0], GROWTH_SQ_Q[cnt]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= (req.divisor == '0) ? WIN_W'(1) : req.divisor;
      rem <= '0;
      quo <= '0;
      cnt <= DIV_CNT_W'(QUO_W - 1);
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, dvs} : trial;
      quo <= {quo[QUO_W-2:0], fits};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: rtl/acrt_ewma.sv
// Shared smoothing unit: (last*230 + sample*16*26 + 128) >> 8, saturated, registered
module acrt_ewma (
  input  logic                          clk,
  input  logic [acrt_pkg::AVG_W-1:0]    last,
  input  logic [acrt_pkg::SAMPLE_W-1:0] sample,
  output logic [acrt_pkg::AVG_W-1:0]    result
);
  import acrt_pkg::*;

  logic [ACC_W-1:0]            acc;
  logic [ACC_W-EWMA_SHIFT-1:0] scaled;

  assign acc = ACC_W'(last) * ACC_W'(ALPHA_KEEP)
             + (ACC_W'(sample) << FRAC_W) * ACC_W'(ALPHA_NEW)
             + ACC_W'(ROUND_BIAS);
  assign scaled = acc[ACC_W-1:EWMA_SHIFT];

  always_ff @(posedge clk) begin
    result <= (scaled[ACC_W-EWMA_SHIFT-1:AVG_W] != '0) ? AVG_MAX : scaled[AVG_W-1:0];
  end

endmodule

// File: rtl/acrt_checker.sv
// Port-level checker for the ack congestion and RTT tracker, bound to the top level
`include "ack_congestion_rtt_tracker_assert.svh"

module acrt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [acrt_pkg::STATUS_W-1:0] status,
  input logic [acrt_pkg::CNT_W-1:0]    acked_count,
  input logic [acrt_pkg::POS_W-1:0]    window_start,
  input logic [acrt_pkg::CNT_W-1:0]    outstanding,
  input logic [acrt_pkg::WIN_W-1:0]    congestion_window,
  input logic                          backoff_cleared
);
  import acrt_pkg::*;

  `ACRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(window_start), "stalled result changed")

  `ACRT_ASSERT_NOW(a_reject_empty,
    out_valid && (status == ST_SEND || status == ST_STALE || status == ST_BEYOND),
    acked_count == '0 && !backoff_cleared, "release or backoff clear without accepted ack")

  `ACRT_ASSERT_NOW(a_accept_releases, out_valid && status == ST_ACCEPTED,
    acked_count != '0, "accepted ack released no atoms")

  `ACRT_ASSERT_NOW(a_window_bounds, out_valid,
    congestion_window != '0 && outstanding <= CAPACITY, "window or count out of range")

endmodule

bind ack_congestion_rtt_tracker acrt_checker u_acrt_checker (.*);

// File: test/ack_congestion_rtt_tracker_tb.sv
// Self-checking testbench for the ack congestion and RTT tracker with a scoreboard class
module ack_congestion_rtt_tracker_tb;
  import acrt_pkg::*;

  localparam logic [63:0]      KEEP_WEIGHT       = 64'd230;
  localparam logic [63:0]      FRESH_WEIGHT      = 64'd26;
  localparam logic [WIN_W-1:0] DEFAULT_THRESHOLD = 24'd65536;
  localparam logic [31:0]      SAMPLE_CAP        = 32'h000F_FFFF;

  typedef struct {
    logic [STATUS_W-1:0] code;
    logic [CNT_W-1:0]    released;
    logic [POS_W-1:0]    base;
    logic [CNT_W-1:0]    in_flight;
    logic [WIN_W-1:0]    window;
    logic [AVG_W-1:0]    rtt;
    logic [AVG_W-1:0]    spread;
    logic                cleared;
  } tracker_result_t;

  class ack_ledger;
    logic [WIN_W-1:0] threshold;
    logic [POS_W-1:0] head_pos;
    int unsigned      open_atoms;
    logic [WIN_W-1:0] cwnd;
    logic [AVG_W-1:0] rtt_avg;
    logic [AVG_W-1:0] spread_avg;
    tracker_result_t  pending[$];
    int               failures;

    function new();
      threshold  = DEFAULT_THRESHOLD;
      head_pos   = '0;
      open_atoms = 0;
      cwnd       = WIN_W'(GROWTH_STEP);
      rtt_avg    = '0;
      spread_avg = '0;
      failures   = 0;
    endfunction

    function logic [AVG_W-1:0] ewma(logic [AVG_W-1:0] prev, logic [31:0] smp);
      logic [63:0] acc;
      acc = (64'(prev) * KEEP_WEIGHT + (64'(smp) << FRAC_W) * FRESH_WEIGHT + 64'd128) >> 8;
      if (acc > 64'hFF_FFFF) acc = 64'hFF_FFFF;
      return acc[AVG_W-1:0];
    endfunction

    function void note_item(logic op, logic [LOW_W-1:0] low, logic [31:0] now,
                            logic resent, logic [31:0] sent);
      tracker_result_t r;
      logic [31:0] pos;
      logic [31:0] rel;
      logic [31:0] smp;
      logic [31:0] whole;
      logic [31:0] dev;
      logic [63:0] nxt;
      r.released = '0;
      r.cleared  = 1'b0;
      if (op == OP_SEND) begin
        if (open_atoms < WINDOW_CAPACITY) open_atoms++;
        r.code = ST_SEND;
      end else begin
        pos = {head_pos[31:16], low};
        if (head_pos > pos && head_pos - pos > 32'h8000) pos = pos + 32'h10000;
        else if (pos > head_pos && pos - head_pos > 32'h8000) pos = pos - 32'h10000;
        rel = pos - head_pos;
        if (rel == 0 || rel[31]) begin
          r.code = ST_STALE;
        end else if (rel > open_atoms) begin
          r.code = ST_BEYOND;
        end else begin
          r.code = ST_ACCEPTED;
          if (cwnd < threshold) nxt = 64'(cwnd) + 64'(GROWTH_STEP);
          else nxt = 64'(cwnd) + (64'(GROWTH_STEP) * 64'(GROWTH_STEP)) /
                     ((cwnd == '0) ? 64'd1 : 64'(cwnd));
          if (nxt > 64'hFF_FFFF) nxt = 64'hFF_FFFF;
          cwnd = nxt[WIN_W-1:0];
          if (!resent) begin
            smp = now - sent;
            if (smp > SAMPLE_CAP) smp = SAMPLE_CAP;
            whole = 32'(rtt_avg >> FRAC_W);
            dev = (smp >= whole) ? smp - whole : whole - smp;
            rtt_avg    = ewma(rtt_avg, smp);
            spread_avg = ewma(spread_avg, dev);
            r.cleared  = 1'b1;
          end
          head_pos   = head_pos + rel;
          open_atoms = open_atoms - rel;
          r.released = rel[CNT_W-1:0];
        end
      end
      r.base      = head_pos;
      r.in_flight = CNT_W'(open_atoms);
      r.window    = cwnd;
      r.rtt       = rtt_avg;
      r.spread    = spread_avg;
      pending.push_back(r);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      failures++;
    endtask

    task check_result(tracker_result_t got);
      tracker_result_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending, window_start", got.base, 0);
      end else begin
        want = pending.pop_front();
        if (got.code !== want.code) report("status", got.code, want.code);
        if (got.released !== want.released) report("acked_count", got.released, want.released);
        if (got.base !== want.base) report("window_start", got.base, want.base);
        if (got.in_flight !== want.in_flight)
          report("outstanding", got.in_flight, want.in_flight);
        if (got.window !== want.window) report("congestion_window", got.window, want.window);
        if (got.rtt !== want.rtt) report("rtt_estimate", got.rtt, want.rtt);
        if (got.spread !== want.spread) report("rtt_spread", got.spread, want.spread);
        if (got.cleared !== want.cleared)
          report("backoff_cleared", got.cleared, want.cleared);
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                operation;
  logic [LOW_W-1:0]    ack_low;
  logic [TIME_W-1:0]   now_time;
  logic                head_resent;
  logic [TIME_W-1:0]   head_send_time;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    acked_count;
  logic [POS_W-1:0]    window_start;
  logic [CNT_W-1:0]    outstanding;
  logic [WIN_W-1:0]    congestion_window;
  logic [AVG_W-1:0]    rtt_estimate;
  logic [AVG_W-1:0]    rtt_spread;
  logic                backoff_cleared;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WIN_W-1:0]    cfg_data;

  ack_ledger ledger;
  bit        calm = 1'b0;
  bit        hold_pending = 1'b0;

  ack_congestion_rtt_tracker u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("ack_congestion_rtt_tracker_tb NOT OK");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    out_ready = 1'b0;
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_pending = 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6))
          @(posedge clk);
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    tracker_result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen = '{status, acked_count, window_start, outstanding, congestion_window,
               rtt_estimate, rtt_spread, backoff_cleared};
      ledger.check_result(seen);
    end
  end

  task automatic pace();
    int g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic offer(input logic op, input logic [LOW_W-1:0] low, input logic [31:0] now,
                       input logic resent, input logic [31:0] sent);
    in_valid       <= 1'b1;
    operation      <= op;
    ack_low        <= low;
    now_time       <= now;
    head_resent    <= resent;
    head_send_time <= sent;
    do @(posedge clk); while (!in_ready);
    ledger.note_item(op, low, now, resent, sent);
    pace();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending.size() != 0);
  endtask

  task automatic write_threshold(input logic [WIN_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    ledger.threshold = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_times(output logic [31:0] now, output logic [31:0] sent);
    int mode;
    mode = $urandom_range(0, 9);
    now  = $urandom;
    case (mode)
      6: sent = now + $urandom_range(1, 1000);
      7: sent = $urandom;
      8: sent = now;
      9: sent = now - (SAMPLE_CAP + 32'($urandom_range(0, 6)) - 32'd3);
      default: sent = now - $urandom_range(0, 2000);
    endcase
  endtask

  task automatic send_atom();
    offer(OP_SEND, LOW_W'($urandom), $urandom, 1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic ack_atoms(input int unsigned rel);
    logic [31:0] now;
    logic [31:0] sent;
    logic [31:0] target;
    pick_times(now, sent);
    target = ledger.head_pos + rel;
    offer(OP_ACK, target[LOW_W-1:0], now, ($urandom_range(0, 3) == 0), sent);
  endtask

  task automatic noise_ack();
    logic [31:0] now;
    logic [31:0] sent;
    logic [31:0] target;
    pick_times(now, sent);
    case ($urandom_range(0, 3))
      0: target = ledger.head_pos;
      1: target = ledger.head_pos - $urandom_range(1, 32'h7FFF);
      2: target = ledger.head_pos + ledger.open_atoms + $urandom_range(1, 32'h6FFF);
      default: target = $urandom;
    endcase
    offer(OP_ACK, target[LOW_W-1:0], now, 1'($urandom_range(0, 1)), sent);
  endtask

  task automatic random_item();
    int r;
    int unsigned span;
    r = $urandom_range(0, 99);
    if (r < 45 || (r < 85 && ledger.open_atoms == 0)) begin
      send_atom();
    end else if (r < 85) begin
      span = ($urandom_range(0, 1) == 0 && ledger.open_atoms > 4) ? 4 : ledger.open_atoms;
      ack_atoms($urandom_range(1, span));
    end else begin
      noise_ack();
    end
  endtask

  task automatic directed_items();
    offer(OP_ACK, 16'h0000, 32'h0, 1'b0, 32'h0);
    offer(OP_ACK, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    offer(OP_ACK, 16'h0001, 32'h0, 1'b0, 32'h0);
    offer(OP_SEND, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    repeat (4) offer(OP_SEND, 16'h0000, 32'h0, 1'b0, 32'h0);
    offer(OP_ACK, 16'h8001, 32'd100, 1'b0, 32'd50);
    offer(OP_ACK, 16'h8000, 32'd100, 1'b0, 32'd50);
    offer(OP_ACK, 16'h0001, 32'd500, 1'b1, 32'd10);
    offer(OP_ACK, 16'h0002, 32'd1000, 1'b0, 32'd990);
    offer(OP_ACK, 16'h0003, 32'd5, 1'b0, 32'hFFFF_FFF0);
    offer(OP_ACK, 16'h0004, 32'hFFFF_FFFF, 1'b0, 32'h0);
    offer(OP_ACK, 16'h0005, 32'h1234_5678, 1'b0, 32'h1234_5678);
    offer(OP_ACK, 16'h0005, 32'd7, 1'b0, 32'd3);
    offer(OP_SEND, 16'h5555, 32'hAAAA_AAAA, 1'b0, 32'h5555_5555);
    offer(OP_ACK, 16'h0006, 32'hAAAA_AAAA, 1'b0, 32'h5555_5555);
  endtask

  task automatic bulk_stream();
    repeat (48) send_atom();
    ack_atoms(ledger.open_atoms);
    repeat (20) begin
      repeat ($urandom_range(1, 4)) send_atom();
      if ($urandom_range(0, 49) == 0) noise_ack();
      ack_atoms($urandom_range(1, ledger.open_atoms));
    end
  endtask

  initial begin
    ledger         = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    operation      = OP_SEND;
    ack_low        = '0;
    now_time       = '0;
    head_resent    = 1'b0;
    head_send_time = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();

    write_threshold(24'd1);
    for (int i = 0; i < 300; i++) begin
      if (i == 100) hold_pending = 1'b1;
      random_item();
    end

    write_threshold(WIN_W'($urandom_range(2048, 300000)));
    for (int i = 0; i < 300; i++) begin
      if (i == 150) drain();
      random_item();
    end

    write_threshold(WIN_MAX);
    calm = 1'b1;
    bulk_stream();
    calm = 1'b0;

    write_threshold(WIN_W'($urandom_range(1, 24'hFF_FFFE)));
    repeat (80) random_item();

    drain();
    repeat (40) @(posedge clk);
    if (ledger.failures == 0) begin
      $display("ack_congestion_rtt_tracker_tb OK");
    end else begin
      $display("ack_congestion_rtt_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
